>>> design/trs_pkg.sv
// Shared types and constants of the tracker row sequencer.
// Used by the configuration registers, the sequencer core, the top level and the testbench.
`default_nettype none

package trs_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_EFFECT = 2'd1,
    KIND_START  = 2'd2
  } kind_t;

  // Row command effect nibbles that the sequencer acts on.
  localparam logic [3:0] EFF_JUMP  = 4'hB;
  localparam logic [3:0] EFF_BREAK = 4'hD;
  localparam logic [3:0] EFF_EXT   = 4'hE;
  localparam logic [3:0] EFF_SPEED = 4'hF;

  // Extended (Exy) subcommands.
  localparam logic [3:0] EXT_LOOP  = 4'h6;
  localparam logic [3:0] EXT_DELAY = 4'hE;

  // Configuration register indexes.
  localparam logic [7:0] REG_ORDER_COUNT = 8'd0;
  localparam logic [7:0] REG_FIRST_ORDER = 8'd1;
  localparam logic [7:0] REG_LAST_ORDER  = 8'd2;
  localparam logic [7:0] REG_LOOP_ENABLE = 8'd3;

  // Configuration reset values.
  localparam logic [7:0] ORDER_COUNT_RESET = 8'd1;
  localparam logic [6:0] FIRST_ORDER_RESET = 7'd0;
  localparam logic [7:0] LAST_ORDER_RESET  = 8'd128;
  localparam logic       LOOP_ENABLE_RESET = 1'b1;

  // A last_order of this value selects the end of the order list.
  localparam logic [7:0] LAST_ORDER_AUTO = 8'd128;

  // Playback constants.
  localparam logic [4:0] SPEED_RESET      = 5'd6;
  localparam logic [7:0] TEMPO_RESET      = 8'd125;
  localparam logic [5:0] TICK_RESET       = 6'd6;
  localparam logic [5:0] TICK_MAX         = 6'd63;
  localparam logic [7:0] SPEED_PARAM_MAX  = 8'h1F;
  localparam logic [7:0] BREAK_DIGIT_BASE = 8'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] effect_code;
    logic [7:0] effect_param;
  } item_t;

  typedef struct packed {
    logic       row_started;
    logic [6:0] order_position;
    logic [5:0] row_index;
    logic [5:0] tick_index;
    logic [4:0] speed_now;
    logic [7:0] tempo_bpm;
    logic       song_ended;
  } result_t;

  typedef struct packed {
    logic [7:0] order_count;
    logic [6:0] first_order;
    logic [7:0] last_order;
    logic       loop_enable;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/trs_ifs.sv
// Valid/ready channel interfaces of the tracker row sequencer: input items,
// result items and configuration writes.
`default_nettype none

interface trs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] effect_code;
  logic [7:0] effect_param;

  modport source(output valid, kind, effect_code, effect_param, input ready);
  modport sink(input valid, kind, effect_code, effect_param, output ready);
endinterface

interface trs_result_if;
  logic       valid;
  logic       ready;
  logic       row_started;
  logic [6:0] order_position;
  logic [5:0] row_index;
  logic [5:0] tick_index;
  logic [4:0] speed_now;
  logic [7:0] tempo_bpm;
  logic       song_ended;

  modport source(output valid, row_started, order_position, row_index, tick_index,
                 speed_now, tempo_bpm, song_ended, input ready);
  modport sink(input valid, row_started, order_position, row_index, tick_index,
               speed_now, tempo_bpm, song_ended, output ready);
endinterface

interface trs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/trs_cfg_regs.sv
// Configuration register file of the tracker row sequencer.
// Depends on trs_pkg and the trs_cfg_if interface.
`default_nettype none

module trs_cfg_regs
  import trs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  trs_cfg_if.sink   cfg,
  output cfg_t      regs
);

  // Writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.order_count <= ORDER_COUNT_RESET;
      regs.first_order <= FIRST_ORDER_RESET;
      regs.last_order  <= LAST_ORDER_RESET;
      regs.loop_enable <= LOOP_ENABLE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_ORDER_COUNT: regs.order_count <= cfg.data;
        REG_FIRST_ORDER: regs.first_order <= cfg.data[6:0];
        REG_LAST_ORDER:  regs.last_order  <= cfg.data;
        REG_LOOP_ENABLE: regs.loop_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/trs_seq_core.sv
// Song position state and its combinational update for one item.
// Depends on trs_pkg; driven by the top level's input register.
`default_nettype none

module trs_seq_core
  import trs_pkg::*;
#(
  parameter int ROWS_PER_PATTERN = 64,
  parameter int MAX_ORDERS       = 128
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int OW = $clog2(MAX_ORDERS);
  localparam int NW = $clog2(MAX_ORDERS + 1);
  localparam int CW = ((NW > 8) ? NW : 8) + 1;
  localparam int RW = $clog2(ROWS_PER_PATTERN + 2);
  localparam int LAST_ROW = ROWS_PER_PATTERN - 1;

  // The row is kept as row number plus one, so "before row 0" is zero.
  logic          playing, playing_next;
  logic          ended, ended_next;
  logic [OW-1:0] order_pos, order_pos_next;
  logic [RW-1:0] row_p1, row_p1_next;
  logic [5:0]    tick_count, tick_count_next;
  logic [4:0]    speed_reg, speed_reg_next;
  logic [7:0]    tempo_reg, tempo_reg_next;
  logic          jump_valid, jump_valid_next;
  logic [OW-1:0] jump_pending, jump_pending_next;
  logic          break_valid, break_valid_next;
  logic [5:0]    break_pending, break_pending_next;
  logic          loop_valid, loop_valid_next;
  logic [5:0]    loop_target, loop_target_next;
  logic [5:0]    loop_start_row, loop_start_row_next;
  logic [3:0]    loop_remaining, loop_remaining_next;
  logic [8:0]    delay_ticks, delay_ticks_next;
  logic [OW-1:0] first_eff, first_eff_next;
  logic [OW-1:0] last_eff, last_eff_next;
  logic          loop_latched, loop_latched_next;
  logic          started;

  logic [CW-1:0] orders_n, orders_m1;
  logic [CW-1:0] first_c, last_c;
  logic [CW-1:0] param_c;
  logic [3:0]    px, py;
  logic [7:0]    break_row;
  logic [5:0]    row_now;
  logic [3:0]    loop_rem_upd;
  logic [5:0]    tick_inc;
  logic [OW-1:0] ord_base;
  logic [RW-1:0] row_base;
  logic [CW-1:0] ord_inc;
  logic [RW-1:0] row_shown;

  function automatic logic [OW-1:0] next_ord(input logic [OW-1:0] o,
                                             input logic [OW-1:0] first,
                                             input logic [OW-1:0] last);
    logic [CW-1:0] inc;
    inc = CW'(o) + CW'(1);
    return (inc > CW'(last)) ? first : OW'(inc);
  endfunction

  // Order count as played: zero acts as one, large values saturate.
  always_comb begin
    if (cfg.order_count == 8'd0) begin
      orders_n = CW'(1);
    end else if (CW'(cfg.order_count) > CW'(MAX_ORDERS)) begin
      orders_n = CW'(MAX_ORDERS);
    end else begin
      orders_n = CW'(cfg.order_count);
    end
    orders_m1 = orders_n - CW'(1);
  end

  always_comb begin
    first_c = (CW'(cfg.first_order) > orders_m1) ? orders_m1 : CW'(cfg.first_order);
    if (cfg.last_order == LAST_ORDER_AUTO || CW'(cfg.last_order) > orders_m1) begin
      last_c = orders_m1;
    end else if (CW'(cfg.last_order) < first_c) begin
      last_c = first_c;
    end else begin
      last_c = CW'(cfg.last_order);
    end
  end

  assign px        = item.effect_param[7:4];
  assign py        = item.effect_param[3:0];
  assign param_c   = CW'(item.effect_param);
  assign break_row = 8'(px) * BREAK_DIGIT_BASE + 8'(py);
  assign row_now   = (row_p1 == '0) ? 6'd0 : 6'(row_p1 - RW'(1));
  assign loop_rem_upd = (loop_remaining == 4'd0) ? py : loop_remaining - 4'd1;
  assign tick_inc  = (tick_count != TICK_MAX) ? tick_count + 6'd1 : tick_count;

  always_comb begin
    playing_next        = playing;
    ended_next          = ended;
    order_pos_next      = order_pos;
    row_p1_next         = row_p1;
    tick_count_next     = tick_count;
    speed_reg_next      = speed_reg;
    tempo_reg_next      = tempo_reg;
    jump_valid_next     = jump_valid;
    jump_pending_next   = jump_pending;
    break_valid_next    = break_valid;
    break_pending_next  = break_pending;
    loop_valid_next     = loop_valid;
    loop_target_next    = loop_target;
    loop_start_row_next = loop_start_row;
    loop_remaining_next = loop_remaining;
    delay_ticks_next    = delay_ticks;
    first_eff_next      = first_eff;
    last_eff_next       = last_eff;
    loop_latched_next   = loop_latched;
    started             = 1'b0;
    ord_base            = order_pos;
    row_base            = row_p1;
    ord_inc             = '0;

    if (item.kind == KIND_START) begin
      first_eff_next      = OW'(first_c);
      last_eff_next       = OW'(last_c);
      loop_latched_next   = cfg.loop_enable;
      speed_reg_next      = SPEED_RESET;
      tempo_reg_next      = TEMPO_RESET;
      order_pos_next      = OW'(first_c);
      row_p1_next         = '0;
      tick_count_next     = TICK_RESET;
      jump_valid_next     = 1'b0;
      jump_pending_next   = '0;
      break_valid_next    = 1'b0;
      break_pending_next  = '0;
      loop_valid_next     = 1'b0;
      loop_target_next    = '0;
      loop_start_row_next = '0;
      loop_remaining_next = '0;
      delay_ticks_next    = '0;
      ended_next          = 1'b0;
      playing_next        = 1'b1;
    end else if (playing && !ended) begin
      if (item.kind == KIND_EFFECT) begin
        case (item.effect_code)
          EFF_JUMP: begin
            jump_pending_next = OW'((param_c < orders_n) ? param_c : orders_m1);
            jump_valid_next   = 1'b1;
          end
          EFF_BREAK: begin
            break_pending_next = (break_row <= 8'(LAST_ROW)) ? break_row[5:0] : 6'd0;
            break_valid_next   = 1'b1;
          end
          EFF_SPEED: begin
            if (item.effect_param <= SPEED_PARAM_MAX) begin
              speed_reg_next = item.effect_param[4:0];
            end else begin
              tempo_reg_next = item.effect_param;
            end
          end
          EFF_EXT: begin
            case (px)
              EXT_LOOP: begin
                if (py == 4'd0) begin
                  loop_start_row_next = row_now;
                end else begin
                  loop_remaining_next = loop_rem_upd;
                  if (loop_rem_upd != 4'd0) begin
                    loop_target_next = loop_start_row;
                    loop_valid_next  = 1'b1;
                  end
                end
              end
              EXT_DELAY: delay_ticks_next = 9'(py) * 9'(speed_reg);
              default: ;
            endcase
          end
          default: ;
        endcase
      end else if (item.kind == KIND_TICK) begin
        if (tick_inc < 6'(speed_reg)) begin
          tick_count_next = tick_inc;
        end else if (delay_ticks != 9'd0) begin
          tick_count_next  = tick_inc;
          delay_ticks_next = delay_ticks - 9'd1;
        end else begin
          // Pending jump beats a break; a loop overrides the row of either.
          if (jump_valid) begin
            row_base        = '0;
            ord_base        = jump_pending;
            jump_valid_next = 1'b0;
          end else if (break_valid) begin
            row_base         = RW'(break_pending);
            ord_base         = next_ord(order_pos, first_eff, last_eff);
            break_valid_next = 1'b0;
          end
          if (loop_valid) begin
            row_base        = RW'(loop_target);
            loop_valid_next = 1'b0;
          end
          tick_count_next = '0;
          row_base        = row_base + RW'(1);
          order_pos_next  = ord_base;
          row_p1_next     = row_base;
          started         = 1'b1;
          if (row_base > RW'(ROWS_PER_PATTERN)) begin
            ord_inc = CW'(ord_base) + CW'(1);
            if (ord_inc > CW'(last_eff)) begin
              order_pos_next = first_eff;
            end else begin
              order_pos_next = OW'(ord_inc);
            end
            if (ord_inc > CW'(last_eff) && !loop_latched) begin
              // Song end: the row stays past the last one and shows clamped.
              ended_next   = 1'b1;
              playing_next = 1'b0;
              started      = 1'b0;
            end else begin
              row_p1_next         = RW'(1);
              loop_start_row_next = '0;
              loop_remaining_next = '0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    logic [CW-1:0] ord_ext;
    ord_ext   = CW'(order_pos_next);
    row_shown = row_p1_next - RW'(1);
    res.row_started    = started;
    res.order_position = ord_ext[6:0];
    if (row_p1_next == '0) begin
      res.row_index = 6'd0;
    end else if (row_shown > RW'(LAST_ROW)) begin
      res.row_index = 6'(LAST_ROW);
    end else begin
      res.row_index = 6'(row_shown);
    end
    res.tick_index = tick_count_next;
    res.speed_now  = speed_reg_next;
    res.tempo_bpm  = tempo_reg_next;
    res.song_ended = ended_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing        <= 1'b0;
      ended          <= 1'b0;
      order_pos      <= '0;
      row_p1         <= '0;
      tick_count     <= TICK_RESET;
      speed_reg      <= SPEED_RESET;
      tempo_reg      <= TEMPO_RESET;
      jump_valid     <= 1'b0;
      jump_pending   <= '0;
      break_valid    <= 1'b0;
      break_pending  <= '0;
      loop_valid     <= 1'b0;
      loop_target    <= '0;
      loop_start_row <= '0;
      loop_remaining <= '0;
      delay_ticks    <= '0;
      first_eff      <= '0;
      last_eff       <= '0;
      loop_latched   <= 1'b1;
    end else if (fire) begin
      playing        <= playing_next;
      ended          <= ended_next;
      order_pos      <= order_pos_next;
      row_p1         <= row_p1_next;
      tick_count     <= tick_count_next;
      speed_reg      <= speed_reg_next;
      tempo_reg      <= tempo_reg_next;
      jump_valid     <= jump_valid_next;
      jump_pending   <= jump_pending_next;
      break_valid    <= break_valid_next;
      break_pending  <= break_pending_next;
      loop_valid     <= loop_valid_next;
      loop_target    <= loop_target_next;
      loop_start_row <= loop_start_row_next;
      loop_remaining <= loop_remaining_next;
      delay_ticks    <= delay_ticks_next;
      first_eff      <= first_eff_next;
      last_eff       <= last_eff_next;
      loop_latched   <= loop_latched_next;
    end
  end

endmodule

`default_nettype wire

>>> design/tracker_row_sequencer_top.sv
// Top level of the tracker row sequencer: input register, sequencer core,
// result register. Depends on trs_pkg, trs_ifs, trs_cfg_regs and trs_seq_core.
//
//   Channel  Direction  Payload                                    Transaction
//   item     in         kind, effect_code, effect_param            valid && ready
//   result   out        row_started, order_position, row_index,    valid && ready
//                       tick_index, speed_now, tempo_bpm, song_ended
//   cfg      in         index, data (register write)               valid && ready
//
// Each item is held in the input register until the result register can load, and then its
// core result sits in the result register until its transaction completes; one item per
// cycle is sustained while the result channel does not stall.
// The whole state update is a single pass through the core between the two registers.
// rst is synchronous: state returns to idle, not playing, and both registers empty.
// A stalled result holds the result register; the input register can still take one item,
// which moves on as soon as the result is taken. cfg writes are taken every cycle.
`default_nettype none

module tracker_row_sequencer_top
  import trs_pkg::*;
#(
  parameter int ROWS_PER_PATTERN = 64,
  parameter int MAX_ORDERS       = 128
) (
  input  logic          clk,
  input  logic          rst,
  trs_item_if.sink      item,
  trs_result_if.source  result,
  trs_cfg_if.sink       cfg
);

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_res;
  result_t core_res;
  cfg_t    cfg_regs;
  logic    out_load;
  logic    fire;

  assign out_load   = !out_valid || result.ready;
  assign fire       = in_valid && out_load;
  assign item.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.kind         <= item.kind;
      in_item.effect_code  <= item.effect_code;
      in_item.effect_param <= item.effect_param;
    end
  end

  trs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  trs_seq_core #(
    .ROWS_PER_PATTERN (ROWS_PER_PATTERN),
    .MAX_ORDERS       (MAX_ORDERS)
  ) u_seq_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg_regs),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= core_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.row_started    = out_res.row_started;
  assign result.order_position = out_res.order_position;
  assign result.row_index      = out_res.row_index;
  assign result.tick_index     = out_res.tick_index;
  assign result.speed_now      = out_res.speed_now;
  assign result.tempo_bpm      = out_res.tempo_bpm;
  assign result.song_ended     = out_res.song_ended;

endmodule

`default_nettype wire

>>> design/trs_checker.sv
// Port-level checks of the tracker row sequencer, attached to the top level by bind.
// Depends only on the top level's result channel and reset.
`default_nettype none

module trs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       row_started,
  input logic [6:0] order_position,
  input logic [5:0] row_index,
  input logic [5:0] tick_index,
  input logic [4:0] speed_now,
  input logic [7:0] tempo_bpm,
  input logic       song_ended
);

  // No result survives a reset.
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_started) &&
      $stable(order_position) && $stable(row_index) && $stable(tick_index) &&
      $stable(speed_now) && $stable(tempo_bpm) && $stable(song_ended))
    else $error("stalled result changed");

  // A new row always restarts the tick count.
  a_row_tick_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_started |-> tick_index == 6'd0)
    else $error("row started with nonzero tick");

  // Once ended, no row can start.
  a_end_no_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && song_ended |-> !row_started)
    else $error("row started after song end");

  // Tempo is only ever the reset value or a parameter above the speed range.
  a_tempo_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tempo_bpm >= 8'd32)
    else $error("tempo below range");

endmodule

bind tracker_row_sequencer_top trs_checker u_trs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .row_started    (result.row_started),
  .order_position (result.order_position),
  .row_index      (result.row_index),
  .tick_index     (result.tick_index),
  .speed_now      (result.speed_now),
  .tempo_bpm      (result.tempo_bpm),
  .song_ended     (result.song_ended)
);

`default_nettype wire

>>> tb/tracker_row_sequencer_top_tb.sv
// Self-checking testbench of the tracker row sequencer: directed and random items and
// register writes, with every result predicted and compared field by field.
// Depends on trs_pkg, the channel interfaces of trs_ifs and tracker_row_sequencer_top.
module tracker_row_sequencer_top_tb
  import trs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS          = 64;
  localparam int LAST_ROW      = ROWS - 1;
  localparam int MAX_ORDERS    = 128;
  localparam int WAIT_MAX      = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 165;
  localparam int SENDER        = 0;
  localparam int RECEIVER      = 1;

  // Kind code that the block has no use for, and a register index with no register.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] REG_UNUSED  = 8'hFC;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trs_item_if   item_ch();
  trs_result_if result_ch();
  trs_cfg_if    cfg_ch();

  tracker_row_sequencer_top #(
    .ROWS_PER_PATTERN(ROWS),
    .MAX_ORDERS(MAX_ORDERS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  item_t   pending_items[$];
  item_t   item_on_bus;
  result_t expected_results[$];
  result_t result_front;
  int      item_hold;
  int      result_hold;
  int      calm_left[2];
  int      failures;
  int      items_taken;
  int      rows_begun;
  int      ended_results;
  int      settings_used;

  // Register copies as the testbench has written them.
  logic [7:0] reg_order_count;
  logic [6:0] reg_first_order;
  logic [7:0] reg_last_order;
  logic       reg_loop_enable;

  // Song position state as predicted.
  logic       song_playing;
  logic       song_over;
  logic [7:0] pos_order;  // one bit wider than the port, so a step past 127 is seen
  int         pos_row;    // -1 before the first row of a pattern
  logic [5:0] pos_tick;
  logic [4:0] ticks_per_row;
  logic [7:0] bpm;
  logic       jump_armed;
  logic       break_armed;
  logic       loop_armed;
  logic [6:0] jump_order;
  logic [5:0] break_row;
  logic [5:0] loop_start;
  logic [5:0] loop_back;
  logic [3:0] loop_left;
  logic [8:0] delay_left;
  logic [6:0] wrap_order;
  logic [6:0] final_order;
  logic       wrap_on;

  function automatic void clear_song_state();
    ticks_per_row = SPEED_RESET;
    bpm           = TEMPO_RESET;
    pos_row       = -1;
    pos_tick      = TICK_RESET;
    jump_armed    = 1'b0;
    break_armed   = 1'b0;
    loop_armed    = 1'b0;
    jump_order    = '0;
    break_row     = '0;
    loop_back     = '0;
    loop_start    = '0;
    loop_left     = '0;
    delay_left    = '0;
    song_over     = 1'b0;
  endfunction

  function automatic int orders_in_list();
    if (reg_order_count == 0) return 1;
    if (reg_order_count > MAX_ORDERS) return MAX_ORDERS;
    return reg_order_count;
  endfunction

  function automatic void restart_song();
    int n;
    int first_i;
    int last_i;
    n = orders_in_list();
    first_i = reg_first_order;
    if (first_i > n - 1) first_i = n - 1;
    if (reg_last_order == LAST_ORDER_AUTO || reg_last_order > n - 1) begin
      last_i = n - 1;
    end else if (reg_last_order < first_i) begin
      last_i = first_i;
    end else begin
      last_i = reg_last_order;
    end
    wrap_order  = first_i[6:0];
    final_order = last_i[6:0];
    wrap_on     = reg_loop_enable;
    clear_song_state();
    pos_order    = {1'b0, wrap_order};
    song_playing = 1'b1;
  endfunction

  function automatic void apply_effect(logic [3:0] code, logic [7:0] p);
    int x;
    int y;
    int r;
    x = p[7:4];
    y = p[3:0];
    case (code)
      EFF_JUMP: begin
        r = (p < orders_in_list()) ? int'(p) : orders_in_list() - 1;
        jump_order = r[6:0];
        jump_armed = 1'b1;
      end
      EFF_BREAK: begin
        r = x * 10 + y;
        if (r > LAST_ROW) r = 0;
        break_row   = r[5:0];
        break_armed = 1'b1;
      end
      EFF_SPEED: begin
        if (p <= SPEED_PARAM_MAX) ticks_per_row = p[4:0];
        else bpm = p;
      end
      EFF_EXT: begin
        if (x == EXT_LOOP) begin
          if (y == 0) begin
            r = (pos_row < 0) ? 0 : pos_row;
            loop_start = r[5:0];
          end else begin
            if (loop_left == 0) loop_left = p[3:0];
            else loop_left--;
            if (loop_left != 0) begin
              loop_back  = loop_start;
              loop_armed = 1'b1;
            end
          end
        end else if (x == EXT_DELAY) begin
          r = y * ticks_per_row;
          delay_left = r[8:0];
        end
      end
      default: ;
    endcase
  endfunction

  // Returns 1 when the tick begins a new row.
  function automatic logic advance_tick();
    if (pos_tick < TICK_MAX) pos_tick++;
    if (pos_tick < ticks_per_row) return 1'b0;
    if (delay_left != 0) begin
      delay_left--;
      return 1'b0;
    end
    if (jump_armed) begin
      pos_row    = -1;
      pos_order  = {1'b0, jump_order};
      jump_armed = 1'b0;
    end else if (break_armed) begin
      pos_row = int'(break_row) - 1;
      pos_order++;
      if (pos_order > final_order) pos_order = {1'b0, wrap_order};
      break_armed = 1'b0;
    end
    if (loop_armed) begin
      pos_row    = int'(loop_back) - 1;
      loop_armed = 1'b0;
    end
    pos_tick = '0;
    pos_row++;
    if (pos_row >= ROWS) begin
      pos_order++;
      if (pos_order > final_order) begin
        pos_order = {1'b0, wrap_order};
        // Without looping the song stops here and the row stays past the end.
        if (!wrap_on) begin
          song_over    = 1'b1;
          song_playing = 1'b0;
          return 1'b0;
        end
      end
      pos_row    = 0;
      loop_start = '0;
      loop_left  = '0;
    end
    return 1'b1;
  endfunction

  function automatic result_t advance_song(item_t it);
    result_t res;
    logic    began;
    int      r;
    began = 1'b0;
    if (it.kind == KIND_START) begin
      restart_song();
    end else if (song_playing && !song_over) begin
      if (it.kind == KIND_TICK) began = advance_tick();
      else if (it.kind == KIND_EFFECT) apply_effect(it.effect_code, it.effect_param);
    end
    r = pos_row;
    if (r < 0) r = 0;
    if (r > LAST_ROW) r = LAST_ROW;
    res.row_started    = began;
    res.order_position = pos_order[6:0];
    res.row_index      = r[5:0];
    res.tick_index     = pos_tick;
    res.speed_now      = ticks_per_row;
    res.tempo_bpm      = bpm;
    res.song_ended     = song_over;
    return res;
  endfunction

  function automatic void apply_register(logic [7:0] idx, logic [7:0] value);
    case (idx)
      REG_ORDER_COUNT: reg_order_count = value;
      REG_FIRST_ORDER: reg_first_order = value[6:0];
      REG_LAST_ORDER:  reg_last_order  = value;
      REG_LOOP_ENABLE: reg_loop_enable = value[0];
      default: ;
    endcase
  endfunction

  function automatic int draw_wait(int side);
    if (calm_left[side] != 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm_left[side] = $urandom_range(10, 50);
    return $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic logic [7:0] pick(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return v[7:0];
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Item driver: presents queued items, predicting each one as its transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_hold = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_results.push_back(advance_song(item_on_bus));
        items_taken++;
        item_hold = draw_wait(SENDER);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (item_hold == 0 && pending_items.size() != 0) begin
          item_on_bus = pending_items.pop_front();
          item_ch.valid        <= 1'b1;
          item_ch.kind         <= item_on_bus.kind;
          item_ch.effect_code  <= item_on_bus.effect_code;
          item_ch.effect_param <= item_on_bus.effect_param;
        end else begin
          item_ch.valid <= 1'b0;
          if (item_hold != 0) item_hold--;
        end
      end
    end
  end

  // Result monitor: stalls at random and checks each transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      result_hold = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no item outstanding");
          failures++;
        end else begin
          result_front = expected_results.pop_front();
          check_field("row_started", result_front.row_started, result_ch.row_started);
          check_field("order_position", result_front.order_position, result_ch.order_position);
          check_field("row_index", result_front.row_index, result_ch.row_index);
          check_field("tick_index", result_front.tick_index, result_ch.tick_index);
          check_field("speed_now", result_front.speed_now, result_ch.speed_now);
          check_field("tempo_bpm", result_front.tempo_bpm, result_ch.tempo_bpm);
          check_field("song_ended", result_front.song_ended, result_ch.song_ended);
          if (result_front.row_started) rows_begun++;
          if (result_front.song_ended) ended_results++;
        end
        result_hold = draw_wait(RECEIVER);
      end
      if (result_hold != 0) begin
        result_ch.ready <= 1'b0;
        result_hold--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic [1:0] k, logic [3:0] code, logic [7:0] p);
    item_t it;
    it.kind         = k;
    it.effect_code  = code;
    it.effect_param = p;
    pending_items.push_back(it);
  endtask

  task automatic push_tick();
    logic [7:0] w;
    w = pick(0, 255);
    push_item(KIND_TICK, w[3:0], pick(0, 255));
  endtask

  task automatic push_random_effect();
    logic [7:0] p;
    logic [7:0] w;
    p = pick(0, 255);
    case (pick(0, 9))
      0: begin
        if (pick(0, 3) != 0) p = pick(0, 9);
        push_item(KIND_EFFECT, EFF_JUMP, p);
      end
      1, 2: begin
        // Mostly decimal row numbers up to 69, now and then any byte.
        if (pick(0, 3) != 0) p = (pick(0, 6) << 4) | pick(0, 9);
        push_item(KIND_EFFECT, EFF_BREAK, p);
      end
      3: begin
        case (pick(0, 2))
          0: p = pick(0, 3);
          1: p = pick(0, SPEED_PARAM_MAX);
          default: ;
        endcase
        push_item(KIND_EFFECT, EFF_SPEED, p);
      end
      4, 5: begin
        w = (pick(0, 4) == 0) ? p : pick(0, 3);
        push_item(KIND_EFFECT, EFF_EXT, {EXT_LOOP, w[3:0]});
      end
      6: begin
        // Long delays are rare so that rows keep moving.
        w = (pick(0, 7) == 0) ? p : pick(0, 2);
        push_item(KIND_EFFECT, EFF_EXT, {EXT_DELAY, w[3:0]});
      end
      7: push_item(KIND_EFFECT, EFF_EXT, p);
      default: begin
        w = pick(0, 15);
        push_item(KIND_EFFECT, w[3:0], p);
      end
    endcase
  endtask

  task automatic push_random(int count);
    int         made;
    logic [7:0] w;
    made = 0;
    while (made < count) begin
      w = pick(0, 99);
      if (w < 3) begin
        w = pick(0, 15);
        push_item(KIND_START, w[3:0], pick(0, 255));
        made++;
      end else if (w < 6) begin
        w = pick(0, 15);
        push_item(KIND_UNUSED, w[3:0], pick(0, 255));
      end else begin
        // A row's commands followed by the ticks that play it.
        repeat (pick(0, 2)) begin
          push_random_effect();
          made++;
        end
        repeat (pick(1, 4)) begin
          push_tick();
          made++;
        end
      end
    end
  endtask

  task automatic push_directed();
    push_tick();
    push_item(KIND_EFFECT, EFF_SPEED, 8'h03);
    push_item(KIND_START, 4'hF, 8'hFF);
    push_tick();
    push_item(KIND_EFFECT, EFF_EXT, {EXT_LOOP, 4'h0});
    push_item(KIND_EFFECT, EFF_SPEED, 8'h00);
    push_tick();
    // Loop twice back to the marked row, then fall through.
    repeat (3) begin
      push_item(KIND_EFFECT, EFF_EXT, {EXT_LOOP, 4'h2});
      push_tick();
    end
    push_item(KIND_EFFECT, EFF_SPEED, SPEED_PARAM_MAX);
    push_item(KIND_EFFECT, EFF_SPEED, 8'h20);
    push_item(KIND_EFFECT, EFF_SPEED, 8'h01);
    push_item(KIND_EFFECT, EFF_EXT, {EXT_DELAY, 4'h2});
    repeat (4) push_tick();
    push_item(KIND_EFFECT, EFF_BREAK, 8'h99);
    push_tick();
    push_item(KIND_EFFECT, EFF_BREAK, 8'h63);
    push_tick();
    push_tick();
    push_item(KIND_EFFECT, EFF_JUMP, 8'hFF);
    push_tick();
    push_item(KIND_EFFECT, EFF_EXT, 8'h05);
    push_item(KIND_EFFECT, 4'h0, 8'h5A);
    push_item(KIND_UNUSED, 4'hA, 8'hC3);
  endtask

  // Called right after a rising edge; leaves valid high for a following write.
  task automatic write_register(logic [7:0] idx, logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_register(idx, value);
  endtask

  task automatic program_registers(logic [7:0] count, logic [7:0] first_pos,
                                   logic [7:0] last_pos, logic [7:0] looping);
    write_register(REG_ORDER_COUNT, count);
    write_register(REG_FIRST_ORDER, first_pos);
    write_register(REG_LAST_ORDER, last_pos);
    write_register(REG_LOOP_ENABLE, looping);
    // A write to an unmapped index must leave every register alone.
    write_register(REG_UNUSED, pick(0, 255));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_TICK;
    item_ch.effect_code  = '0;
    item_ch.effect_param = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    reg_order_count      = ORDER_COUNT_RESET;
    reg_first_order      = FIRST_ORDER_RESET;
    reg_last_order       = LAST_ORDER_RESET;
    reg_loop_enable      = LOOP_ENABLE_RESET;
    clear_song_state();
    song_playing = 1'b0;
    pos_order    = '0;
    wrap_order   = '0;
    final_order  = '0;
    wrap_on      = 1'b1;
    settings_used = 1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values first, with the directed items.
    push_directed();
    push_random(PHASE_ITEMS);
    wait_idle();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: program_registers(8'd0, 8'd0, 8'd0, 8'd0);
        2: program_registers(8'd128, 8'hFF, LAST_ORDER_AUTO, 8'hFF);
        3: program_registers(8'd255, 8'd3, 8'd255, 8'h02);
        4: program_registers(8'd3, 8'd2, 8'd1, 8'd0);
        default: program_registers(pick(1, 6), pick(0, 7),
                                   (pick(0, 3) == 0) ? LAST_ORDER_AUTO : pick(0, 8),
                                   pick(0, 255));
      endcase
      push_item(KIND_START, 4'h0, 8'h00);
      if (phase == 2) begin
        // A delay longer than the tick counter can hold.
        push_tick();
        push_item(KIND_EFFECT, EFF_EXT, {EXT_DELAY, 4'hB});
        repeat (70) push_tick();
      end
      push_random(PHASE_ITEMS);
      wait_idle();
    end

    $display("Checked %0d items over %0d register settings.", items_taken, settings_used);
    $display("%0d rows began, %0d results reported a finished song.", rows_begun,
             ended_results);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
design/trs_pkg.sv
design/trs_ifs.sv
design/trs_cfg_regs.sv
design/trs_seq_core.sv
design/tracker_row_sequencer_top.sv
design/trs_checker.sv
tb/tracker_row_sequencer_top_tb.sv
